FILE: rtl/core/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and constants of the parameter ramp engine.
// ----------------------------------------------------------------------------
package pre_pkg;

    localparam int NUM_PARAMS_DEF = 32;

    localparam int IDX_W   = 5;
    localparam int CODE_W  = 10;
    localparam int PHASE_W = 4;
    localparam int VAL_W   = 16;
    localparam int RATE_W  = 16;
    localparam int PART_W  = 6;
    localparam int CELL_W  = VAL_W + CODE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_3    = 3'd4;

    // target code that freezes a cell
    localparam logic [CODE_W-1:0] CODE_HOLD    = 10'h200;
    // positive codes below this one get the +1 rounding
    localparam logic [CODE_W-1:0] CODE_RND_TOP = 10'h1ff;
    // rounding bias added to the 17 fraction bits of the product
    localparam logic [17:0]       FRAC_BIAS    = 18'h01000;
    localparam logic [4:0]        FRAC_FULL    = 5'd16;
    // error used when ramping down lands exactly on the rounded target
    localparam logic [16:0]       TERM_ERR     = 17'h1fffe;

    typedef struct packed {
        logic                tick;
        logic [IDX_W-1:0]    idx;
        logic [CODE_W-1:0]   code;
        logic [PHASE_W-1:0]  thr;
    } t_cmd;

endpackage

FILE: rtl/core/pre_ram.sv
// ----------------------------------------------------------------------------
// pre_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/pre_front.sv
// ----------------------------------------------------------------------------
// pre_front
// Input side: accepts words, drops sets to missing cells, forms the dither
// threshold and queues commands for the ramp back end.
// ----------------------------------------------------------------------------
module pre_front #(
    parameter int NUM_PARAMS = pre_pkg::NUM_PARAMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_tick,
    input  logic [5:0]                i_idx,
    input  logic [pre_pkg::CODE_W-1:0]  i_code,
    input  logic [pre_pkg::PHASE_W-1:0] i_phase,
    output logic                      o_cmd_valid,
    output pre_pkg::t_cmd             o_cmd,
    input  logic                      i_cmd_pop
);
    import pre_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       keep;
    logic       push;
    t_cmd       cmd_in;

    // upper half of the host index aliases the lower half
    assign keep = i_tick || (32'(i_idx[IDX_W-1:0]) < NUM_PARAMS);
    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready && keep;

    always_comb begin
        cmd_in.tick = i_tick;
        cmd_in.idx  = i_idx[IDX_W-1:0];
        cmd_in.code = i_code;
        // bit-reversed phase is the rounding threshold
        cmd_in.thr  = {i_phase[0], i_phase[1], i_phase[2], i_phase[3]};
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

endmodule

FILE: rtl/core/pre_back.sv
// ----------------------------------------------------------------------------
// pre_back
// Ramp back end: walks the cells of a tick one per cycle while the output
// is taken, via a read, error, multiply, update pipeline; applies target writes.
// ----------------------------------------------------------------------------
module pre_back #(
    parameter int NUM_PARAMS = pre_pkg::NUM_PARAMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pre_pkg::PART_W-1:0]        i_partition,
    input  logic [3:0][pre_pkg::RATE_W-1:0]   i_rate,
    input  logic                              i_cmd_valid,
    input  pre_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pre_pkg::IDX_W-1:0]         o_param,
    output logic [pre_pkg::VAL_W-1:0]         o_current,
    output logic [pre_pkg::CODE_W-1:0]        o_target,
    output logic                              o_last
);
    import pre_pkg::*;

    localparam int AW    = $clog2(NUM_PARAMS);
    localparam int LIMIT = (NUM_PARAMS < 32) ? NUM_PARAMS : 32;
    localparam logic [PART_W-1:0] LIMIT_P = PART_W'(LIMIT);
    localparam logic [PART_W-1:0] LAST_P  = PART_W'(LIMIT - 1);

    // control
    logic              r_issuing;
    logic [PART_W-1:0] r_p;
    logic [PHASE_W-1:0] r_thr;
    logic              r_b_valid, r_c_valid, r_d_valid, r_out_valid;
    logic              r_ok [NUM_PARAMS];

    logic adv;
    logic pipe_empty;
    logic cmd_pop;

    // issue
    logic              iss_valid;
    logic              iss_tick;
    logic [PART_W-1:0] iss_p;
    logic              iss_last;
    logic [CELL_W-1:0] ram_rdata;
    logic              ram_we;
    logic [CELL_W-1:0] ram_wdata;

    // stage b: read data
    logic              r_b_tick, r_b_last, r_b_ok;
    logic [PART_W-1:0] r_b_p;
    logic [PHASE_W-1:0] r_b_thr;
    logic [CODE_W-1:0] r_b_code;
    logic [CELL_W-1:0] b_cell;
    logic [CODE_W-1:0] b_low;
    logic [VAL_W-1:0]  b_cur;
    logic [VAL_W-1:0]  b_exact;
    logic [16:0]       b_dir;
    logic [16:0]       b_diff0;
    logic [16:0]       b_diff;
    logic [16:0]       b_ndiff;
    logic              b_rnd_inc;
    logic              b_neg;

    // stage c: error terms
    logic              r_c_tick, r_c_last, r_c_skip, r_c_neg;
    logic [AW-1:0]     r_c_addr;
    logic [IDX_W-1:0]  r_c_p;
    logic [PHASE_W-1:0] r_c_thr;
    logic [VAL_W-1:0]  r_c_mag;
    logic [RATE_W-1:0] r_c_rate;
    logic [VAL_W-1:0]  r_c_cur, r_c_exact;
    logic [CODE_W-1:0] r_c_low;
    logic [CELL_W-1:0] r_c_wcell;

    // stage d: product
    logic              r_d_tick, r_d_last, r_d_skip, r_d_neg;
    logic [AW-1:0]     r_d_addr;
    logic [IDX_W-1:0]  r_d_p;
    logic [PHASE_W-1:0] r_d_thr;
    logic [31:0]       r_d_prod;
    logic [VAL_W-1:0]  r_d_cur, r_d_exact;
    logic [CODE_W-1:0] r_d_low;
    logic [CELL_W-1:0] r_d_wcell;
    logic [17:0]       d_fsum;
    logic [4:0]        d_frac0, d_frac;
    logic              d_wrap, d_bump;
    logic [16:0]       d_delta;
    logic signed [17:0] d_next, d_ex18, d_cur18;
    logic [VAL_W-1:0]  d_clamped, d_val;

    // output register
    logic [IDX_W-1:0]  r_out_p;
    logic [VAL_W-1:0]  r_out_cur;
    logic [CODE_W-1:0] r_out_tgt;
    logic              r_out_last;

    assign adv        = !r_out_valid || i_ready;
    assign pipe_empty = !r_issuing && !r_b_valid && !r_c_valid && !r_d_valid;
    assign cmd_pop    = adv && pipe_empty && i_cmd_valid;
    assign o_cmd_pop  = cmd_pop;

    always_comb begin
        iss_valid = 1'b0;
        iss_tick  = 1'b1;
        iss_p     = r_p;
        iss_last  = (r_p == LAST_P);
        if (r_issuing) begin
            iss_valid = 1'b1;
        end else if (cmd_pop && !i_cmd.tick) begin
            iss_valid = 1'b1;
            iss_tick  = 1'b0;
            iss_p     = {1'b0, i_cmd.idx};
            iss_last  = 1'b0;
        end
    end

    pre_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NUM_PARAMS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_d_addr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (iss_p[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // stage b: error toward the target
    always_comb begin
        b_cell    = r_b_ok ? ram_rdata : '0;
        b_low     = b_cell[CODE_W-1:0];
        b_cur     = b_cell[CELL_W-1:CODE_W];
        b_exact   = {b_low, 6'b0};
        b_dir     = {b_exact[VAL_W-1], b_exact} - {b_cur[VAL_W-1], b_cur};
        b_rnd_inc = (b_low != '0) && (b_low < CODE_RND_TOP);
        b_diff0   = b_dir + {16'b0, b_rnd_inc};
        b_neg     = b_dir[16];
        b_diff    = (b_neg && (b_diff0 == '0)) ? TERM_ERR : b_diff0;
        b_ndiff   = -b_diff;
    end

    // stage d: rounding, step and clamp
    always_comb begin
        d_fsum  = {1'b0, r_d_prod[16:0]} + FRAC_BIAS;
        d_frac0 = d_fsum[17:13];
        d_wrap  = (d_frac0 == FRAC_FULL);
        d_frac  = d_wrap ? 5'd0 : d_frac0;
        d_bump  = (!r_d_neg && ({1'b0, r_d_thr} < d_frac)) ||
                  (r_d_neg && (d_frac != 5'd0) && ({1'b0, r_d_thr} >= (FRAC_FULL - d_frac)));
        d_delta = {2'b0, r_d_prod[31:17]} + {16'b0, d_wrap} + {16'b0, d_bump};
        d_cur18 = {{2{r_d_cur[VAL_W-1]}}, r_d_cur};
        d_ex18  = {{2{r_d_exact[VAL_W-1]}}, r_d_exact};
        d_next  = r_d_neg ? (d_cur18 - $signed({1'b0, d_delta}))
                          : (d_cur18 + $signed({1'b0, d_delta}));
        if ((!r_d_neg && (d_next > d_ex18)) || (r_d_neg && (d_next < d_ex18))) begin
            d_clamped = r_d_exact;
        end else begin
            d_clamped = d_next[VAL_W-1:0];
        end
        d_val = r_d_skip ? r_d_cur : d_clamped;
    end

    assign ram_we    = adv && r_d_valid;
    assign ram_wdata = r_d_tick ? {d_val, r_d_low} : r_d_wcell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PARAMS; i++) begin
                r_ok[i] <= 1'b0;
            end
        end else if (adv) begin
            if (r_issuing) begin
                r_p <= r_p + 1'b1;
                if (iss_last) begin
                    r_issuing <= 1'b0;
                end
            end else if (cmd_pop && i_cmd.tick && (i_partition < LIMIT_P)) begin
                r_issuing <= 1'b1;
                r_p       <= i_partition;
                r_thr     <= i_cmd.thr;
            end
            r_b_valid   <= iss_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_out_valid <= r_d_valid && r_d_tick;
            if (r_d_valid) begin
                r_ok[r_d_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_tick <= iss_tick;
            r_b_last <= iss_last;
            r_b_p    <= iss_p;
            r_b_thr  <= r_thr;
            r_b_code <= i_cmd.code;
            r_b_ok   <= r_ok[iss_p[AW-1:0]];

            r_c_tick  <= r_b_tick;
            r_c_last  <= r_b_last;
            r_c_addr  <= r_b_p[AW-1:0];
            r_c_p     <= r_b_p[IDX_W-1:0];
            r_c_thr   <= r_b_thr;
            r_c_skip  <= (b_low == CODE_HOLD) || (b_dir == '0);
            r_c_neg   <= b_neg;
            r_c_mag   <= b_diff[16] ? b_ndiff[VAL_W-1:0] : b_diff[VAL_W-1:0];
            r_c_rate  <= i_rate[r_b_p[1:0]];
            r_c_cur   <= b_cur;
            r_c_exact <= b_exact;
            r_c_low   <= b_low;
            // set below the partition clears the current value
            r_c_wcell <= (r_b_p < i_partition) ? {{VAL_W{1'b0}}, r_b_code}
                                               : {b_cur, r_b_code};

            r_d_tick  <= r_c_tick;
            r_d_last  <= r_c_last;
            r_d_addr  <= r_c_addr;
            r_d_p     <= r_c_p;
            r_d_thr   <= r_c_thr;
            r_d_skip  <= r_c_skip;
            r_d_neg   <= r_c_neg;
            r_d_prod  <= r_c_mag * r_c_rate;
            r_d_cur   <= r_c_cur;
            r_d_exact <= r_c_exact;
            r_d_low   <= r_c_low;
            r_d_wcell <= r_c_wcell;

            r_out_p    <= r_d_p;
            r_out_cur  <= d_val;
            r_out_tgt  <= r_d_low;
            r_out_last <= r_d_last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_param   = r_out_p;
    assign o_current = r_out_cur;
    assign o_target  = r_out_tgt;
    assign o_last    = r_out_last;

    a_pop_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (!r_b_valid && !r_c_valid && !r_d_valid))
        else $error("command taken while the pipeline is busy");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (r_p < LIMIT_P))
        else $error("tick walk beyond the last cell");

    a_last_is_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_p == LAST_P[IDX_W-1:0]))
        else $error("last word not on the top cell");

    a_walk_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_issuing) |-> $past(cmd_pop))
        else $error("tick walk started without a command");

    a_moving_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_tick && !r_c_skip) |-> (r_c_mag != '0))
        else $error("ramping cell with zero error");

endmodule

FILE: rtl/core/parameter_ramp_engine.sv
// Flow: a tick word accepted into an idle engine passes the command queue and
// the read, error, product and output registers, then yields one word per cycle
// while the output is taken. Issue: the back end takes a new command only once
// its pipeline has drained; a tick walks its cells through the single cell RAM
// port and the one multiplier. A two-entry command queue lets the input run ahead.
// Reset: synchronous active low; clears the control and configuration registers and the cell valid bits.
// ----------------------------------------------------------------------------
// parameter_ramp_engine
// Parameter cells with target writes and dithered ramp ticks.
// ----------------------------------------------------------------------------
module parameter_ramp_engine #(
    parameter int NUM_PARAMS = pre_pkg::NUM_PARAMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pre_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // param_index[5:0], target_code[15:6], rounding_phase[19:16], zero[23:20]
    input  logic [23:0]                    s_axis_tdata,
    // action[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_param[4:0], out_current[20:5], out_target[30:21], zero[31]
    output logic [31:0]                    m_axis_tdata,
    output logic                           m_axis_tlast
);
    import pre_pkg::*;

    logic [PART_W-1:0]        r_partition;
    logic [3:0][RATE_W-1:0]   r_rate;
    logic                     cmd_valid;
    t_cmd                     cmd;
    logic                     cmd_pop;
    logic [IDX_W-1:0]         out_p;
    logic [VAL_W-1:0]         out_cur;
    logic [CODE_W-1:0]        out_tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partition <= '0;
            r_rate      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PARTITION: r_partition <= i_cfg_data[PART_W-1:0];
                REG_RATE_0:    r_rate[0]   <= i_cfg_data[RATE_W-1:0];
                REG_RATE_1:    r_rate[1]   <= i_cfg_data[RATE_W-1:0];
                REG_RATE_2:    r_rate[2]   <= i_cfg_data[RATE_W-1:0];
                REG_RATE_3:    r_rate[3]   <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pre_front #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_tick      (s_axis_tuser),
        .i_idx       (s_axis_tdata[5:0]),
        .i_code      (s_axis_tdata[15:6]),
        .i_phase     (s_axis_tdata[19:16]),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    pre_back #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_partition (r_partition),
        .i_rate      (r_rate),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_param     (out_p),
        .o_current   (out_cur),
        .o_target    (out_tgt),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_tgt, out_cur, out_p};

endmodule

FILE: bench/parameter_ramp_engine_tb.sv
// ----------------------------------------------------------------------------
// parameter_ramp_engine_tb
// Drives set and tick words into the ramp engine and follows every cell in a
// local slew tracker. Each reported cell word is compared field by field with
// the oldest report the tracker has queued. A directed table opens the run,
// then random phases with fresh partition and rate settings follow, with
// random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module parameter_ramp_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pre_pkg::*;

    localparam int NUM_CELLS     = NUM_PARAMS_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 34;
    localparam int RANDOM_PHASES = 6;

    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {ROW_SET, ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
        logic [5:0]             idx;
        logic [CODE_W-1:0]      code;
        logic [PHASE_W-1:0]     phase;
        logic                   pinned;
        logic signed [VAL_W-1:0] pinned_cur;
    } t_stim_row;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] cur;
        logic [CODE_W-1:0]       code;
        logic                    tail;
    } t_cell_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    // table-pinned current value, travels beside the word it belongs to
    logic                    pin_cur_en;
    logic signed [VAL_W-1:0] pin_cur;

    // slew tracker state
    logic signed [VAL_W-1:0] cell_value [NUM_CELLS];
    logic [CODE_W-1:0]       cell_code  [NUM_CELLS];
    logic [PART_W-1:0]       ramp_first;
    logic [RATE_W-1:0]       ramp_rate  [4];
    t_cell_report            ramp_reports [$];

    t_stim_row dir_rows [$];
    int        bad_words;
    int        cycle_count;
    bit        steady;
    bit        hold_req;

    parameter_ramp_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("parameter_ramp_engine_tb failed");
        $finish;
    end

    // tracks cells on accepted input words, checks reported cell words
    always @(posedge i_clk) begin : slew_tracker
        t_cell_report            want;
        logic [CODE_W-1:0]       code;
        logic signed [CODE_W-1:0] scode;
        logic [PHASE_W-1:0]      thr;
        int                      cur, exact, dir, err, step, nxt;
        bit [31:0]               mag, prod, frac;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (ramp_reports.size() == 0) begin
                    $error("unexpected cell word: param %0d current %0d target 0x%0h",
                           m_axis_tdata[4:0], $signed(m_axis_tdata[20:5]),
                           m_axis_tdata[30:21]);
                    bad_words++;
                end else begin
                    want = ramp_reports.pop_front();
                    if (m_axis_tdata[4:0] !== want.idx) begin
                        $error("out_param: expected %0d, got %0d", want.idx,
                               m_axis_tdata[4:0]);
                        bad_words++;
                    end
                    if (m_axis_tdata[20:5] !== want.cur) begin
                        $error("out_current: expected %0d, got %0d", want.cur,
                               $signed(m_axis_tdata[20:5]));
                        bad_words++;
                    end
                    if (m_axis_tdata[30:21] !== want.code) begin
                        $error("out_target: expected 0x%0h, got 0x%0h", want.code,
                               m_axis_tdata[30:21]);
                        bad_words++;
                    end
                    if (m_axis_tlast !== want.tail) begin
                        $error("last: expected %0b, got %0b", want.tail, m_axis_tlast);
                        bad_words++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ACT_SET) begin
                    // below the partition the whole cell is rewritten
                    if (s_axis_tdata[4:0] < ramp_first)
                        cell_value[s_axis_tdata[4:0]] = '0;
                    cell_code[s_axis_tdata[4:0]] = s_axis_tdata[15:6];
                end else begin
                    // dither threshold is the phase bit-reversed
                    thr = {s_axis_tdata[16], s_axis_tdata[17], s_axis_tdata[18],
                           s_axis_tdata[19]};
                    for (int p = ramp_first; p < NUM_CELLS; p++) begin
                        code  = cell_code[p];
                        scode = code;
                        cur   = cell_value[p];
                        exact = scode * 64;
                        dir   = exact - cur;
                        if (code != CODE_HOLD && dir != 0) begin
                            err = dir + ((code != '0 && code < CODE_RND_TOP) ? 1 : 0);
                            if (dir < 0 && err == 0)
                                err = -2;
                            mag  = (err < 0) ? -err : err;
                            prod = mag * ramp_rate[p % 4];
                            step = int'(prod >> 17);
                            frac = ((prod & 32'h1ffff) + 32'h1000) >> 13;
                            if (frac == 16) begin
                                step++;
                                frac = 0;
                            end
                            if ((err > 0 && thr < frac) ||
                                (err < 0 && frac != 0 && thr >= 16 - frac))
                                step++;
                            nxt = (dir < 0) ? cur - step : cur + step;
                            if ((dir > 0 && nxt > exact) || (dir < 0 && nxt < exact))
                                nxt = exact;
                            cell_value[p] = 16'(nxt);
                        end
                        want.idx  = 5'(p);
                        want.cur  = pin_cur_en ? pin_cur : cell_value[p];
                        want.code = cell_code[p];
                        want.tail = (p == NUM_CELLS - 1);
                        ramp_reports.push_back(want);
                    end
                end
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        int held;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge i_clk);
            end
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic offer_word(input logic act, input logic [5:0] idx,
                              input logic [CODE_W-1:0] code,
                              input logic [PHASE_W-1:0] phase, input logic pinned,
                              input logic signed [VAL_W-1:0] pinned_cur);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'd0, phase, code, idx};
        pin_cur_en    <= pinned;
        pin_cur       <= pinned_cur;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and let the engine run dry
    task automatic drain_engine();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ramp_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data  <= v;
        case (ri)
            REG_PARTITION: ramp_first   = v[PART_W-1:0];
            REG_RATE_0:    ramp_rate[0] = v;
            REG_RATE_1:    ramp_rate[1] = v;
            REG_RATE_2:    ramp_rate[2] = v;
            REG_RATE_3:    ramp_rate[3] = v;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_stim_row         row;
        logic [PART_W-1:0] part;
        logic [5:0]        idx;
        logic [CODE_W-1:0] code;
        logic [CFG_W-1:0]  rate;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_SET;
        pin_cur_en    <= 1'b0;
        pin_cur       <= '0;
        bad_words  = 0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        ramp_first = '0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            cell_value[i] = '0;
            cell_code[i]  = '0;
        end
        for (int i = 0; i < 4; i++)
            ramp_rate[i] = '0;

        // all cells sit at zero after reset, zero rates move nothing
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'h0, 1'b1, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd63, 10'h3ff, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd0, 10'h1ff, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'hf, 1'b1, 16'sd0});
        dir_rows.push_back('{ROW_CFG, REG_RATE_0, 16'hffff, 6'd0, 10'h000, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_CFG, REG_RATE_1, 16'hffff, 6'd0, 10'h000, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_CFG, REG_RATE_2, 16'hffff, 6'd0, 10'h000, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_CFG, REG_RATE_3, 16'hffff, 6'd0, 10'h000, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_CFG, REG_PARTITION, 16'd28, 6'd0, 10'h000, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd28, 10'h002, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd29, CODE_HOLD, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd30, 10'h001, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd31, 10'h000, 4'h0, 1'b0, 16'sd0});
        // cell 28 lands one above the next target, so the ramp down hits the -2 error
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd28, 10'h001, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'h6, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd60, 10'h201, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd27, 10'h155, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'h9, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'hf, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'h5, 1'b0, 16'sd0});
        // nothing ramps once the partition covers every cell
        dir_rows.push_back('{ROW_CFG, REG_PARTITION, 16'd32, 6'd0, 10'h000, 4'h0, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_TICK, REG_PARTITION, 16'h0, 6'd0, 10'h000, 4'h3, 1'b0, 16'sd0});
        dir_rows.push_back('{ROW_SET, REG_PARTITION, 16'h0, 6'd5, 10'h2aa, 4'h0, 1'b0, 16'sd0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    drain_engine();
                    write_reg(row.reg_idx, row.reg_val);
                end
                ROW_SET:
                    offer_word(ACT_SET, row.idx, row.code, row.phase, 1'b0, '0);
                default:
                    offer_word(ACT_TICK, row.idx, row.code, row.phase, row.pinned,
                               row.pinned_cur);
            endcase
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_engine();
            case (ph)
                0: part = 6'd24;
                1: part = 6'd0;
                2: part = 6'd32;
                3: part = 6'd31;
                4: part = 6'($urandom_range(16, 32));
                default: part = 6'($urandom_range(0, 32));
            endcase
            write_reg(REG_PARTITION, 16'(part));
            for (int r = 0; r < 4; r++) begin
                case ($urandom_range(0, 7))
                    0, 1: rate = 16'hffff;
                    2: rate = 16'h0000;
                    default: rate = 16'($urandom_range(0, 65535));
                endcase
                write_reg(REG_RATE_0 + 3'(r), rate);
            end
            // full-width ticks queue up behind a stalled output
            if (ph == 1) begin
                steady   = 1'b0;
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 12 == 0 && !(ph == 1 && k == 0))
                    steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) == 1) begin
                    offer_word(ACT_TICK, 6'($urandom_range(0, 63)),
                               10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)),
                               1'b0, '0);
                end else begin
                    if (part < NUM_CELLS && $urandom_range(0, 1) == 1)
                        idx = {1'($urandom_range(0, 1)), 5'($urandom_range(part, 31))};
                    else
                        idx = 6'($urandom_range(0, 63));
                    case ($urandom_range(0, 11))
                        0: code = 10'h000;
                        1: code = 10'h001;
                        2: code = 10'h1fe;
                        3: code = CODE_RND_TOP;
                        4: code = CODE_HOLD;
                        5: code = 10'h201;
                        6: code = 10'h3ff;
                        default: code = 10'($urandom_range(0, 1023));
                    endcase
                    offer_word(ACT_SET, idx, code, 4'($urandom_range(0, 15)), 1'b0, '0);
                end
            end
        end

        drain_engine();
        if (bad_words == 0)
            $display("parameter_ramp_engine_tb passed");
        else
            $display("parameter_ramp_engine_tb failed");
        $finish;
    end

endmodule
